### hw/rtl/lpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

    // coordinate width of every endpoint and pixel field
    localparam int COORD_WIDTH = 12;
    // width of the interpolation numerator: coordinate times difference, plus a sum
    localparam int NUM_WIDTH = 2 * COORD_WIDTH + 3;

    // action codes of a request word
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // request word
    typedef struct packed {
        logic        action;
        coord_t      x_start;
        coord_t      y_start;
        coord_t      x_end;
        coord_t      y_end;
        logic [31:0] line_color;
    } req_word_t;

    // pixel word
    typedef struct packed {
        coord_t      pixel_x;
        coord_t      pixel_y;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pix_word_t;

    // divider start and operand magnitudes
    typedef struct packed {
        logic                   start;
        logic [NUM_WIDTH-1:0]   num;
        logic [COORD_WIDTH-1:0] den;
    } div_req_t;

    // divider finish pulse and quotient magnitude
    typedef struct packed {
        logic                   done;
        logic [COORD_WIDTH-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/lpg_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider on magnitudes, one quotient bit per cycle
// the quotient is known to fit in COORD_WIDTH bits, so only that many steps run
module lpg_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lpg_pkg::div_req_t req,
    output lpg_pkg::div_rsp_t      rsp
);

    localparam int W  = lpg_pkg::COORD_WIDTH;
    localparam int NW = lpg_pkg::NUM_WIDTH;
    localparam int RW = NW - W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [W-1:0]  den_reg, den_next;

    logic [RW:0]   trial;
    logic [RW:0]   den_ext;
    logic          fits;

    // trial subtract of the shifted remainder
    assign trial   = {rem_reg, lo_reg[W-1]};
    assign den_ext = {{(RW + 1 - W){1'b0}}, den_reg};
    assign fits    = (trial >= den_ext);

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            rem_next  = req.num[NW-1:W];
            lo_next   = req.num[W-1:0];
            den_next  = req.den;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? RW'(trial - den_ext) : trial[RW-1:0];
            // quotient bits enter where the numerator bits leave
            lo_next  = {lo_reg[W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            lo_reg   <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
            den_reg  <= den_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = lo_reg;

`ifndef NO_ASSERTIONS
    // a new division never cuts into a running one
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // finish follows the last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider finish without a running division");
`endif

endmodule

`default_nettype wire

### hw/rtl/line_pixel_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer that hands out one pixel per request word. A load word (action 0)
// latches two endpoints and a color; it drops any line still in progress. Each next
// word (action 1) yields one pixel word with a last mark; a next word with no line
// active yields nothing. Vertical lines walk y directly: the accepting step and one
// finishing step per pixel. Lines with x_start below x_end walk x from x_start to
// x_end and then, if not flat, y from its low to its high end; lines with x_start
// above x_end walk only y, or nothing if flat. For each pixel of a non-vertical line,
// two steps on the shared multiplier build the interpolation numerator, one step
// starts the divider, a one-bit-per-cycle divider produces the truncated quotient,
// and one step moves the pixel out once the output register is free. The block takes
// one request at a time and holds req_stall high until the pixel is in the output
// register, which lets the next request in while the pixel still waits on pix_stall.
module line_pixel_generator
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire lpg_pkg::req_word_t req_word,
    output logic                    pix_valid,
    input  wire logic               pix_stall,
    output lpg_pkg::pix_word_t      pix_word
);

    localparam int W  = lpg_pkg::COORD_WIDTH;
    localparam int NW = lpg_pkg::NUM_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_VERT,
        PH_XWALK,
        PH_YWALK
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_PREP,
        S_DIV,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    lpg_pkg::coord_t      ax_reg, ax_next;
    lpg_pkg::coord_t      ay_reg, ay_next;
    lpg_pkg::coord_t      bx_reg, bx_next;
    lpg_pkg::coord_t      by_reg, by_next;
    logic signed [W:0]    dx_reg, dx_next;
    logic signed [W:0]    dy_reg, dy_next;
    logic [31:0]          color_reg, color_next;
    lpg_pkg::coord_t      walk_reg, walk_next;
    lpg_pkg::coord_t      pos_reg, pos_next;
    logic                 mode_y_reg, mode_y_next;
    logic                 neg_reg, neg_next;
    logic signed [NW-1:0] acc_reg, acc_next;
    lpg_pkg::coord_t      res_x_reg, res_x_next;
    lpg_pkg::coord_t      res_y_reg, res_y_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    lpg_pkg::pix_word_t   out_word_reg, out_word_next;

    lpg_pkg::coord_t      min_y, max_y;
    lpg_pkg::coord_t      ld_min_y;
    logic signed [W:0]    ax_ext, ay_ext, pos_ext;
    logic signed [W:0]    mul_a, mul_b;
    logic signed [2*W+1:0] prod;
    logic [W-1:0]         den_abs;
    logic [W-1:0]         q_signed;
    logic                 accept;

    lpg_pkg::div_req_t    div_req;
    lpg_pkg::div_rsp_t    div_rsp;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);

    // walk bounds of the latched line and of a line being loaded
    assign min_y    = (ay_reg < by_reg) ? ay_reg : by_reg;
    assign max_y    = (ay_reg > by_reg) ? ay_reg : by_reg;
    assign ld_min_y = (req_word.y_start < req_word.y_end) ? req_word.y_start : req_word.y_end;

    assign ax_ext  = {ax_reg[W-1], ax_reg};
    assign ay_ext  = {ay_reg[W-1], ay_reg};
    assign pos_ext = {pos_reg[W-1], pos_reg};

    // shared multiplier operands: anchor term first, then the offset term
    always_comb
    begin
        if (state_reg == S_MUL0)
        begin
            mul_a = mode_y_reg ? ax_ext : ay_ext;
            mul_b = mode_y_reg ? dy_reg : dx_reg;
        end
        else
        begin
            mul_a = mode_y_reg ? (pos_ext - ay_ext) : dy_reg;
            mul_b = mode_y_reg ? dx_reg : (pos_ext - ax_ext);
        end
    end

    assign prod = mul_a * mul_b;

    // divider operands as magnitudes
    assign den_abs       = W'(mode_y_reg ? (dy_reg[W] ? -dy_reg : dy_reg)
                                         : (dx_reg[W] ? -dx_reg : dx_reg));
    assign div_req.start = (state_reg == S_PREP);
    assign div_req.num   = acc_reg[NW-1] ? NW'(-acc_reg) : NW'(acc_reg);
    assign div_req.den   = den_abs;

    assign q_signed = neg_reg ? (~div_rsp.quot + W'(1)) : div_rsp.quot;

    lpg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        color_next     = color_reg;
        walk_next      = walk_reg;
        pos_next       = pos_reg;
        mode_y_next    = mode_y_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        // output register drains independently
        if (out_valid_reg && !pix_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_word.action == lpg_pkg::ACT_LOAD)
                    begin
                        ax_next    = req_word.x_start;
                        ay_next    = req_word.y_start;
                        bx_next    = req_word.x_end;
                        by_next    = req_word.y_end;
                        dx_next    = {req_word.x_end[W-1], req_word.x_end}
                                   - {req_word.x_start[W-1], req_word.x_start};
                        dy_next    = {req_word.y_end[W-1], req_word.y_end}
                                   - {req_word.y_start[W-1], req_word.y_start};
                        color_next = req_word.line_color;
                        if (req_word.x_start == req_word.x_end)
                        begin
                            phase_next = PH_VERT;
                            walk_next  = ld_min_y;
                        end
                        else if (req_word.x_start < req_word.x_end)
                        begin
                            phase_next = PH_XWALK;
                            walk_next  = req_word.x_start;
                        end
                        else if (req_word.y_start != req_word.y_end)
                        begin
                            phase_next = PH_YWALK;
                            walk_next  = ld_min_y;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            walk_next  = '0;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_VERT:
                            begin
                                res_x_next = ax_reg;
                                res_y_next = walk_reg;
                                state_next = S_FIN;
                                if (walk_reg >= max_y)
                                begin
                                    last_next  = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    last_next = 1'b0;
                                    walk_next = walk_reg + W'(1);
                                end
                            end
                            PH_XWALK:
                            begin
                                res_x_next  = walk_reg;
                                pos_next    = walk_reg;
                                mode_y_next = 1'b0;
                                state_next  = S_MUL0;
                                last_next   = 1'b0;
                                if (walk_reg >= bx_reg)
                                begin
                                    // x walk done: hand over to the y walk unless flat
                                    if (ay_reg != by_reg)
                                    begin
                                        phase_next = PH_YWALK;
                                        walk_next  = min_y;
                                    end
                                    else
                                    begin
                                        last_next  = 1'b1;
                                        phase_next = PH_IDLE;
                                    end
                                end
                                else
                                begin
                                    walk_next = walk_reg + W'(1);
                                end
                            end
                            PH_YWALK:
                            begin
                                res_y_next  = walk_reg;
                                pos_next    = walk_reg;
                                mode_y_next = 1'b1;
                                state_next  = S_MUL0;
                                if (walk_reg >= max_y)
                                begin
                                    last_next  = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    last_next = 1'b0;
                                    walk_next = walk_reg + W'(1);
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_MUL0:
            begin
                acc_next   = {prod[2*W+1], prod};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = acc_reg + {prod[2*W+1], prod};
                state_next = S_PREP;
            end
            S_PREP:
            begin
                // quotient sign: numerator sign against divisor sign
                neg_next   = acc_reg[NW-1] ^ (mode_y_reg ? dy_reg[W] : dx_reg[W]);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (mode_y_reg)
                    begin
                        res_x_next = q_signed;
                    end
                    else
                    begin
                        res_y_next = q_signed;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !pix_stall)
                begin
                    out_word_next.pixel_x     = res_x_reg;
                    out_word_next.pixel_y     = res_y_reg;
                    out_word_next.pixel_color = color_reg;
                    out_word_next.last_pixel  = last_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            ax_reg        <= '0;
            ay_reg        <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            color_reg     <= '0;
            walk_reg      <= '0;
            pos_reg       <= '0;
            mode_y_reg    <= 1'b0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            bx_reg        <= bx_next;
            by_reg        <= by_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            color_reg     <= color_next;
            walk_reg      <= walk_next;
            pos_reg       <= pos_next;
            mode_y_reg    <= mode_y_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            res_x_reg     <= res_x_next;
            res_y_reg     <= res_y_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_word  = out_word_reg;

`ifndef NO_ASSERTIONS
    // a pixel only appears out of the finishing step
    a_pix_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(state_reg == S_FIN))
        else $error("pixel word without a finished computation");

    // the divider only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    // walk position never passes the inclusive end of its walk
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_VERT || phase_reg == PH_YWALK) |-> walk_reg <= max_y)
        and (phase_reg == PH_XWALK |-> walk_reg <= bx_reg))
        else $error("walk position beyond line end");

    // an empty output register is filled right away at the finishing step
    a_fin_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !pix_valid) |=> pix_valid && state_reg == S_IDLE)
        else $error("finished pixel not moved into the output register");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_WORDS = 1650;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 3 * (lpg_pkg::COORD_WIDTH + 6);
    localparam int WALK_BUDGET  = 48;
    localparam int PRINT_LIMIT  = 50;
    localparam int CW           = lpg_pkg::COORD_WIDTH;

    typedef enum logic [1:0] {WALK_IDLE, WALK_VERT, WALK_X, WALK_Y} walk_phase_t;

    // one row of the directed table; typed rows carry their pixel written out
    typedef struct {
        lpg_pkg::req_word_t word;
        bit                 typed;
        bit                 has_pix;
        lpg_pkg::pix_word_t pix;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    lpg_pkg::req_word_t req_word;
    logic               pix_valid;
    logic               pix_stall;
    lpg_pkg::pix_word_t pix_word;

    // line state as the rasterizer should hold it
    int          line_ax;
    int          line_ay;
    int          line_bx;
    int          line_by;
    logic [31:0] held_rgba;
    walk_phase_t walk_phase;
    int          walk_at;

    lpg_pkg::pix_word_t pending_pixels [$];
    stim_row_t          directed_rows [$];
    lpg_pkg::pix_word_t want;
    int                 mismatch_count;
    int                 words_counted;
    int                 cycle_count;
    bit                 quiet_spell;
    int                 stall_left;

    line_pixel_generator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // next pixel of the line, or nothing; loads latch a new line
    function automatic bit raster_next(input lpg_pkg::req_word_t w,
                                       output lpg_pkg::pix_word_t p);
        longint dx;
        longint dy;
        int     px;
        int     py;
        int     y_low;
        int     y_high;
        bit     last_flag;
        p         = '0;
        px        = 0;
        py        = 0;
        last_flag = 1'b0;
        if (w.action == lpg_pkg::ACT_LOAD)
        begin
            line_ax   = w.x_start;
            line_ay   = w.y_start;
            line_bx   = w.x_end;
            line_by   = w.y_end;
            held_rgba = w.line_color;
        end
        y_low  = (line_ay < line_by) ? line_ay : line_by;
        y_high = (line_ay > line_by) ? line_ay : line_by;
        if (w.action == lpg_pkg::ACT_LOAD)
        begin
            if (line_ax == line_bx)
            begin
                walk_phase = WALK_VERT;
                walk_at    = y_low;
            end
            else if (line_ax < line_bx)
            begin
                walk_phase = WALK_X;
                walk_at    = line_ax;
            end
            else if (line_ay != line_by)
            begin
                walk_phase = WALK_Y;
                walk_at    = y_low;
            end
            else
            begin
                walk_phase = WALK_IDLE;
                walk_at    = 0;
            end
            return 1'b0;
        end
        dx = longint'(line_bx) - line_ax;
        dy = longint'(line_by) - line_ay;
        // integer division truncates toward zero, as the quotients require
        case (walk_phase)
            WALK_VERT:
            begin
                px = line_ax;
                py = walk_at;
                if (walk_at >= y_high)
                begin
                    last_flag  = 1'b1;
                    walk_phase = WALK_IDLE;
                end
                else
                    walk_at++;
            end
            WALK_X:
            begin
                px = walk_at;
                py = int'((longint'(line_ay) * dx + dy * longint'(walk_at - line_ax)) / dx);
                if (walk_at >= line_bx)
                begin
                    if (line_ay != line_by)
                    begin
                        walk_phase = WALK_Y;
                        walk_at    = y_low;
                    end
                    else
                    begin
                        last_flag  = 1'b1;
                        walk_phase = WALK_IDLE;
                    end
                end
                else
                    walk_at++;
            end
            WALK_Y:
            begin
                py = walk_at;
                px = int'((longint'(line_ax) * dy + longint'(walk_at - line_ay) * dx) / dy);
                if (walk_at >= y_high)
                begin
                    last_flag  = 1'b1;
                    walk_phase = WALK_IDLE;
                end
                else
                    walk_at++;
            end
            default:
                return 1'b0;
        endcase
        p.pixel_x     = px[CW-1:0];
        p.pixel_y     = py[CW-1:0];
        p.pixel_color = held_rgba;
        p.last_pixel  = last_flag;
        return 1'b1;
    endfunction

    // idle length: mostly none or short, now and then long, none in a quiet spell
    function automatic int pick_gap();
        int r;
        if (quiet_spell)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int near_coord(input int v);
        int r;
        r = v + int'($urandom_range(0, 20)) - 10;
        if (r > 2047)
            r = 2047;
        if (r < -2048)
            r = -2048;
        return r;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 5))
            0:       return -2048;
            1:       return 2047;
            2:       return -2047;
            3:       return 2046;
            4:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic lpg_pkg::req_word_t load_word(input int x0, input int y0,
                                                     input int x1, input int y1,
                                                     input logic [31:0] rgba);
        lpg_pkg::req_word_t w;
        w.action     = lpg_pkg::ACT_LOAD;
        w.x_start    = x0[CW-1:0];
        w.y_start    = y0[CW-1:0];
        w.x_end      = x1[CW-1:0];
        w.y_end      = y1[CW-1:0];
        w.line_color = rgba;
        return w;
    endfunction

    // next word: the endpoint and color fields carry noise the block ignores
    function automatic lpg_pkg::req_word_t next_word();
        lpg_pkg::req_word_t w;
        w        = load_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        w.action = lpg_pkg::ACT_NEXT;
        return w;
    endfunction

    function automatic lpg_pkg::req_word_t random_line();
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = int'($urandom_range(0, 4095)) - 2048;
        y0 = int'($urandom_range(0, 4095)) - 2048;
        x1 = near_coord(x0);
        y1 = near_coord(y0);
        case ($urandom_range(0, 9))
            0: x1 = x0;
            1: y1 = y0;
            // start beyond end in x
            7:
            begin
                if (x0 < -2038)
                    x0 = -2038;
                x1 = x0 - int'($urandom_range(1, 10));
                if ($urandom_range(0, 3) == 0)
                    y1 = y0;
            end
            8:
            begin
                x1 = int'($urandom_range(0, 4095)) - 2048;
                y1 = int'($urandom_range(0, 4095)) - 2048;
            end
            9:
            begin
                x0 = edge_coord();
                y0 = edge_coord();
                x1 = edge_coord();
                y1 = edge_coord();
            end
            default: ;
        endcase
        return load_word(x0, y0, x1, y1, $urandom());
    endfunction

    function automatic stim_row_t plain_row(input lpg_pkg::req_word_t w);
        stim_row_t row;
        row.word    = w;
        row.typed   = 1'b0;
        row.has_pix = 1'b0;
        row.pix     = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input bit has_pix, input int x, input int y,
                                            input logic [31:0] rgba, input bit last_flag);
        stim_row_t row;
        row.word              = next_word();
        row.typed             = 1'b1;
        row.has_pix           = has_pix;
        row.pix.pixel_x       = x[CW-1:0];
        row.pix.pixel_y       = y[CW-1:0];
        row.pix.pixel_color   = rgba;
        row.pix.last_pixel    = last_flag;
        return row;
    endfunction

    // drive one request word, wait for it to be taken, record its pixel
    task automatic send_word(input stim_row_t row);
        lpg_pkg::pix_word_t predicted;
        bit                 produced;
        int                 gap;
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= row.word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        produced = raster_next(row.word, predicted);
        if (row.typed)
        begin
            produced  = row.has_pix;
            predicted = row.pix;
        end
        if (produced)
            pending_pixels.push_back(predicted);
        if (produced || row.word.action == lpg_pkg::ACT_LOAD)
            words_counted++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // quiet spells with no idling on either side
    initial
    begin
        quiet_spell = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400))
                @(posedge clk);
            quiet_spell = !quiet_spell;
        end
    end

    // pixel side backpressure
    initial
    begin
        pix_stall  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pix_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                pix_stall  <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // pixel check against the oldest pending pixel
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT)
                    $display("%0t: pixel with none pending: x=%0d y=%0d color=%h last=%b",
                             $time, pix_word.pixel_x, pix_word.pixel_y,
                             pix_word.pixel_color, pix_word.last_pixel);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_word.pixel_x !== want.pixel_x || pix_word.pixel_y !== want.pixel_y ||
                    pix_word.pixel_color !== want.pixel_color ||
                    pix_word.last_pixel !== want.last_pixel)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                        $display("%0t: exp x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                                 $time, want.pixel_x, want.pixel_y, want.pixel_color,
                                 want.last_pixel, pix_word.pixel_x, pix_word.pixel_y,
                                 pix_word.pixel_color, pix_word.last_pixel);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int budget;
        int steps;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_word       = '0;
        mismatch_count = 0;
        words_counted  = 0;
        cycle_count    = 0;
        line_ax        = 0;
        line_ay        = 0;
        line_bx        = 0;
        line_by        = 0;
        held_rgba      = '0;
        walk_phase     = WALK_IDLE;
        walk_at        = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // next while idle after reset
        directed_rows.push_back(typed_row(0, 0, 0, 32'h0, 0));
        // vertical line at the low x extreme, up to the high y extreme
        directed_rows.push_back(plain_row(load_word(-2048, 2047, -2048, 2045, 32'hFFFF_FFFF)));
        directed_rows.push_back(typed_row(1, -2048, 2045, 32'hFFFF_FFFF, 0));
        directed_rows.push_back(typed_row(1, -2048, 2046, 32'hFFFF_FFFF, 0));
        directed_rows.push_back(typed_row(1, -2048, 2047, 32'hFFFF_FFFF, 1));
        directed_rows.push_back(typed_row(0, 0, 0, 32'h0, 0));
        // flat line ending on the high x extreme
        directed_rows.push_back(plain_row(load_word(2045, -2048, 2047, -2048, 32'h0)));
        directed_rows.push_back(typed_row(1, 2045, -2048, 32'h0, 0));
        directed_rows.push_back(typed_row(1, 2046, -2048, 32'h0, 0));
        directed_rows.push_back(typed_row(1, 2047, -2048, 32'h0, 1));
        // start beyond end in x, not flat: y walk only
        directed_rows.push_back(plain_row(load_word(5, 0, 3, 2, 32'hA5A5_A5A5)));
        directed_rows.push_back(plain_row(next_word()));
        directed_rows.push_back(plain_row(next_word()));
        directed_rows.push_back(plain_row(next_word()));
        // start beyond end in x and flat: no pixels at all
        directed_rows.push_back(plain_row(load_word(10, 7, -10, 7, 32'h1234_5678)));
        directed_rows.push_back(typed_row(0, 0, 0, 32'h0, 0));
        // corner to corner, cut short by the next load
        directed_rows.push_back(plain_row(load_word(-2048, 2047, 2047, -2048, 32'h0F0F_0F0F)));
        directed_rows.push_back(typed_row(1, -2048, 2047, 32'h0F0F_0F0F, 0));
        directed_rows.push_back(plain_row(next_word()));
        // short line through the x walk into the y walk
        directed_rows.push_back(plain_row(load_word(0, 0, 1, -2, 32'h8000_0001)));
        repeat (5)
            directed_rows.push_back(plain_row(next_word()));
        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        // random lines, mostly walked to the end, some abandoned by a new load
        words_counted = 0;
        while (words_counted < RANDOM_WORDS)
        begin
            send_word(plain_row(random_line()));
            budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : WALK_BUDGET;
            steps  = 0;
            while (walk_phase != WALK_IDLE && steps < budget)
            begin
                send_word(plain_row(next_word()));
                steps++;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    send_word(plain_row(next_word()));
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // drain
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_div.sv
hw/rtl/line_pixel_generator.sv
tb/testbench.sv
